// ----- design/llca_pkg.sv -----
`default_nettype none
package llca_pkg;

    localparam int CELL_W  = 16;
    localparam int MASK_W  = 9;
    localparam int RULE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int LANES   = 4;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_BIRTH_MASK   = 3'd0,
        REG_SURVIVE_MASK = 3'd1,
        REG_HEX_MODE     = 3'd2,
        REG_WOLFRAM_MODE = 3'd3,
        REG_WOLFRAM_RULE = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
        logic              hex;
        logic              wolfram;
        logic [RULE_W-1:0] rule;
    } rule_t;

    function automatic logic [MASK_W-1:0] mirror9(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] out;
        for (int j = 0; j < MASK_W; j++) begin
            out[j] = m[MASK_W-1-j];
        end
        return out;
    endfunction

endpackage
`default_nettype wire

// ----- design/life_like_ca_block_update.sv -----
// Channel  Direction  Ports                                   Transfer
// s_       in         s_cell_block[15:0], s_odd_generation    s_valid & s_ready
// m_       out        m_next_cells[3:0]                       m_valid & m_ready
// apb      in/out     psel penable pwrite paddr pwdata prdata write when psel&penable&pwrite
//
// One item per cycle unless m_ready stalls; each result appears in the cycle after
// its transfer, from the single output register after the four cell lanes.
// s_ready is high whenever the output register is empty or being drained.
// A stall on m_ready holds the result and blocks new input transfers.
// Reset (aresetn low, synchronous) empties the output and restores the rule.
`default_nettype none
module life_like_ca_block_update
    import llca_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire [CELL_W-1:0]   s_cell_block,
    input  wire                s_odd_generation,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [LANES-1:0]   m_next_cells,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [PADDR_W-1:0]  paddr,
    input  wire [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [MASK_W-1:0] birth_mask_reg;
    logic [MASK_W-1:0] survive_mask_reg;
    logic              hex_mode_reg;
    logic              wolfram_mode_reg;
    logic [RULE_W-1:0] wolfram_rule_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [LANES-1:0]  next_cells_reg;
    logic [LANES-1:0]  next_cells_next;
    logic [LANES-1:0]  lane_out;
    logic              wr_en;
    reg_idx_t          reg_idx;
    rule_t             cfg;
    rule_t             eff;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            birth_mask_reg   <= MASK_W'(8);
            survive_mask_reg <= MASK_W'(12);
            hex_mode_reg     <= 1'b0;
            wolfram_mode_reg <= 1'b0;
            wolfram_rule_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BIRTH_MASK:   birth_mask_reg   <= pwdata[MASK_W-1:0];
                REG_SURVIVE_MASK: survive_mask_reg <= pwdata[MASK_W-1:0];
                REG_HEX_MODE:     hex_mode_reg     <= pwdata[0];
                REG_WOLFRAM_MODE: wolfram_mode_reg <= pwdata[0];
                REG_WOLFRAM_RULE: wolfram_rule_reg <= {pwdata[RULE_W-1:1], 1'b0};
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BIRTH_MASK:   prdata = PDATA_W'(birth_mask_reg);
            REG_SURVIVE_MASK: prdata = PDATA_W'(survive_mask_reg);
            REG_HEX_MODE:     prdata = PDATA_W'(hex_mode_reg);
            REG_WOLFRAM_MODE: prdata = PDATA_W'(wolfram_mode_reg);
            REG_WOLFRAM_RULE: prdata = PDATA_W'(wolfram_rule_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg = '{birth:   birth_mask_reg,
                   survive: survive_mask_reg,
                   hex:     hex_mode_reg,
                   wolfram: wolfram_mode_reg,
                   rule:    wolfram_rule_reg};

    llca_rule_sel u_rule_sel (
        .cfg            (cfg),
        .odd_generation (s_odd_generation),
        .eff            (eff)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        llca_lane #(
            .ROW (1 + g / 2),
            .COL (1 + g % 2)
        ) u_lane (
            .cell_block (s_cell_block),
            .rule       (eff),
            .next_cell  (lane_out[g])
        );
    end

    assign s_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        next_cells_next = next_cells_reg;
        if (s_valid && s_ready) begin
            m_valid_next    = 1'b1;
            next_cells_next = lane_out;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        next_cells_reg <= next_cells_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_next_cells = next_cells_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid_reg)
        else $error("output not empty after reset");

    a_transfer_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid_reg)
        else $error("accepted item lost");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    a_rule_even: assert property (@(posedge aclk) disable iff (!aresetn)
        wolfram_rule_reg[0] == 1'b0)
        else $error("elementary rule bit 0 set");

    a_wolfram_live: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && wolfram_mode_reg && s_cell_block[5] |=> m_next_cells[0])
        else $error("live cell died in elementary mode");

endmodule
`default_nettype wire

// ----- design/llca_rule_sel.sv -----
`default_nettype none
module llca_rule_sel
    import llca_pkg::*;
(
    input  var rule_t cfg,
    input  wire       odd_generation,
    output var rule_t eff
);

    always_comb begin
        eff = cfg;
        if (!cfg.wolfram && cfg.birth[0]) begin
            priority if (cfg.survive[MASK_W-1]) begin
                eff.birth   = mirror9(~cfg.survive);
                eff.survive = mirror9(~cfg.birth);
            end else if (!odd_generation) begin
                eff.birth   = ~cfg.birth;
                eff.survive = ~cfg.survive;
            end else begin
                eff.birth   = mirror9(cfg.survive);
                eff.survive = mirror9(cfg.birth);
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/llca_lane.sv -----
`default_nettype none
module llca_lane
    import llca_pkg::*;
#(
    parameter int ROW = 1,
    parameter int COL = 1
) (
    input  wire [CELL_W-1:0] cell_block,
    input  var rule_t        rule,
    output logic             next_cell
);

    localparam int CTR = ROW * 4 + COL;
    localparam int UP  = CTR - 4;
    localparam int DN  = CTR + 4;

    logic               centre;
    logic [COUNT_W-1:0] hex_count;
    logic [COUNT_W-1:0] count;
    logic [2:0]         w_idx;

    assign centre = cell_block[CTR];

    always_comb begin
        hex_count = COUNT_W'(cell_block[UP-1]) + COUNT_W'(cell_block[UP])
                  + COUNT_W'(cell_block[CTR-1]) + COUNT_W'(cell_block[CTR+1])
                  + COUNT_W'(cell_block[DN]) + COUNT_W'(cell_block[DN+1]);
        count = hex_count;
        if (!rule.hex) begin
            count = hex_count + COUNT_W'(cell_block[UP+1]) + COUNT_W'(cell_block[DN-1]);
        end
    end

    assign w_idx = {cell_block[DN+1], cell_block[DN], cell_block[DN-1]};

    always_comb begin
        if (rule.wolfram) begin
            next_cell = centre | rule.rule[w_idx];
        end else if (centre) begin
            next_cell = rule.survive[count];
        end else begin
            next_cell = rule.birth[count];
        end
    end

endmodule
`default_nettype wire
